FILE: design/drp_pkg.sv
`timescale 1ns / 1ps
package drp_pkg;

	// Event codes reported on the result channel
	typedef enum logic [2:0] {
		EV_TOUCH     = 3'd0,
		EV_PAGE      = 3'd1,
		EV_READY     = 3'd2,
		EV_ERROR     = 3'd3,
		EV_MALFORMED = 3'd4,
		EV_UNKNOWN   = 3'd5,
		EV_OVERFLOW  = 3'd6,
		EV_TIMEOUT   = 3'd7
	} event_kind_t;

	// First four data bytes of a frame, entry 0 is the type byte
	typedef logic [3:0][7:0] head_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  first_arg;
		logic [7:0]  second_arg;
		logic        pressed;
		logic [6:0]  frame_length;
	} result_t;

	localparam logic [7:0]  TERM_BYTE      = 8'hFF;
	// Pending terminator count at which the next 0xFF completes the terminator
	localparam logic [1:0]  TERM_LAST      = 2'd2;
	localparam logic [7:0]  TYPE_TOUCH     = 8'h65;
	localparam logic [7:0]  TYPE_PAGE      = 8'h66;
	localparam logic [7:0]  TYPE_READY     = 8'h88;
	localparam logic [7:0]  TYPE_ERR_A     = 8'h00;
	localparam logic [7:0]  TYPE_ERR_B     = 8'h1A;
	localparam logic [7:0]  TYPE_ERR_C     = 8'h1B;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
	localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

endpackage

FILE: design/drp_classify.sv
`timescale 1ns / 1ps
module drp_classify #(
	parameter int LEN_W = 7
) (
	input  drp_pkg::head_t      head,
	input  logic [LEN_W-1:0]    length,
	output drp_pkg::result_t    res
);
	import drp_pkg::*;

	logic [LEN_W+6:0] len_ext;
	logic [7:0]       type_byte;
	logic             len_is_1;
	logic             len_is_2;
	logic             len_is_4;

	assign len_ext   = {7'b0, length};
	assign type_byte = head[0];
	assign len_is_1  = (length == LEN_W'(1));
	assign len_is_2  = (length == LEN_W'(2));
	assign len_is_4  = (length == LEN_W'(4));

	// Decode frame type and check its length
	always_comb begin
		res              = '0;
		res.frame_length = len_ext[6:0];
		res.first_arg    = type_byte;
		res.kind         = EV_MALFORMED;
		case (type_byte)
			TYPE_TOUCH: begin
				if (len_is_4 && (head[3] <= 8'd1)) begin
					res.kind       = EV_TOUCH;
					res.first_arg  = head[1];
					res.second_arg = head[2];
					res.pressed    = head[3][0];
				end
			end
			TYPE_PAGE: begin
				if (len_is_2) begin
					res.kind      = EV_PAGE;
					res.first_arg = head[1];
				end
			end
			TYPE_READY: begin
				if (len_is_1) begin
					res.kind      = EV_READY;
					res.first_arg = 8'd0;
				end
			end
			TYPE_ERR_A, TYPE_ERR_B, TYPE_ERR_C: begin
				if (len_is_1) begin
					res.kind = EV_ERROR;
				end
			end
			default: begin
				res.kind = EV_UNKNOWN;
			end
		endcase
	end

endmodule

FILE: design/display_reply_frame_parser.sv
`timescale 1ns / 1ps
// Reply-frame parser for a serial display link.
// Input channel (in_valid / in_stall): one transaction per received byte
// (command = 0, rx_byte) or per millisecond tick (command = 1). Frames end
// with three 0xFF bytes; one or two 0xFF followed by another byte are data.
// Output channel (out_valid / out_stall): at most one event per input
// transaction: touch, page, ready, error, malformed, unknown type,
// overflow (frame buffer full, bytes dropped up to the next terminator)
// or timeout (partial frame idle for timeout_ticks ticks).
// Configuration: cfg_we writes cfg_wdata into timeout_ticks (reset 100,
// zero acts as one); write it only while the block is idle.
// An accepted transaction enters the input register; its event is parsed
// combinationally and loaded into the output register once that register
// is free or not stalled.
// One transaction is taken per cycle while the output register is free or
// not stalled; the parse between input and output registers is combinational.
// Stall: while out_stall holds a waiting event, the input register holds
// its transaction and in_stall is raised; a transaction that gives no
// event still waits for the output register to free.
// Reset clears the frame state and both register valids, and restores
// timeout_ticks to 100.
module display_reply_frame_parser #(
	parameter int FRAME_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  first_arg,
	output logic [7:0]  second_arg,
	output logic        pressed,
	output logic [6:0]  frame_length,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import drp_pkg::*;

	localparam int              LEN_W = $clog2(FRAME_CAPACITY + 1);
	localparam logic [LEN_W:0]  CAP_X = (LEN_W + 1)'(FRAME_CAPACITY);

	logic             valid_s1;
	logic             command_s1;
	logic [7:0]       rx_byte_s1;

	logic [LEN_W-1:0] length_q, length_n;
	logic [1:0]       term_q, term_n;
	logic             disc_q, disc_n;
	logic [15:0]      idle_q, idle_n;
	logic [15:0]      timeout_q;
	head_t            head_q, head_n;

	logic             out_valid_q;
	result_t          res_q;

	logic             adv;
	logic             emit;
	result_t          res;
	result_t          cls_res;

	logic [15:0]      limit;
	logic [15:0]      idle_inc;
	logic             partial;
	logic [LEN_W:0]   need;
	logic [LEN_W+6:0] len_ext;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign limit    = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign partial  = (length_q != '0) || (term_q != 2'd0) || disc_q;
	assign need     = {1'b0, length_q} + (LEN_W + 1)'(term_q) + (LEN_W + 1)'(1);
	assign len_ext  = {7'b0, length_q};

	drp_classify #(
		.LEN_W (LEN_W)
	) u_classify (
		.head   (head_q),
		.length (length_q),
		.res    (cls_res)
	);

	// Parse one transaction against the frame state
	always_comb begin
		logic [LEN_W:0] d;
		length_n = length_q;
		term_n   = term_q;
		disc_n   = disc_q;
		idle_n   = idle_q;
		head_n   = head_q;
		emit     = 1'b0;
		res      = '0;
		d        = '0;
		if (command_s1) begin
			idle_n = idle_inc;
			if (partial && (idle_inc >= limit)) begin
				length_n         = '0;
				term_n           = 2'd0;
				disc_n           = 1'b0;
				idle_n           = 16'd0;
				emit             = 1'b1;
				res.kind         = EV_TIMEOUT;
				res.frame_length = len_ext[6:0];
			end
		end else begin
			idle_n = 16'd0;
			if (rx_byte_s1 == TERM_BYTE) begin
				if (term_q == TERM_LAST) begin
					if (!disc_q && (length_q != '0)) begin
						emit = 1'b1;
						res  = cls_res;
					end
					length_n = '0;
					term_n   = 2'd0;
					disc_n   = 1'b0;
				end else begin
					term_n = term_q + 2'd1;
				end
			end else if (disc_q) begin
				term_n = 2'd0;
			end else begin
				term_n = 2'd0;
				if (need > CAP_X) begin
					length_n = '0;
					disc_n   = 1'b1;
					emit     = 1'b1;
					res.kind = EV_OVERFLOW;
				end else begin
					length_n = need[LEN_W-1:0];
					// Put back pending 0xFF bytes, then the new byte
					for (int i = 0; i < 4; i++) begin
						d = (LEN_W + 1)'(i) - {1'b0, length_q};
						if (({1'b0, length_q} <= (LEN_W + 1)'(i)) && (d < need - {1'b0, length_q})) begin
							head_n[i] = (d < (LEN_W + 1)'(term_q)) ? TERM_BYTE : rx_byte_s1;
						end
					end
				end
			end
		end
	end

	// Input register: load when the stage ahead frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
		end
	end

	// Frame state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= '0;
			term_q    <= 2'd0;
			disc_q    <= 1'b0;
			idle_q    <= 16'd0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			if (adv) begin
				length_q <= length_n;
				term_q   <= term_n;
				disc_q   <= disc_n;
				idle_q   <= idle_n;
			end
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_q <= head_n;
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = res_q.kind;
	assign first_arg    = res_q.first_arg;
	assign second_arg   = res_q.second_arg;
	assign pressed      = res_q.pressed;
	assign frame_length = res_q.frame_length;

endmodule

FILE: design/drp_checker.sv
`timescale 1ns / 1ps
module drp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_kind,
	input logic [7:0] first_arg,
	input logic [7:0] second_arg,
	input logic       pressed,
	input logic [6:0] frame_length
);
	import drp_pkg::*;

	// Input backs up only behind a held event
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held event");

	// Held event keeps its kind, first argument and frame length
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_kind)
			&& $stable(first_arg) && $stable(frame_length)))
		else $error("held event changed");

	// Touch events carry a four-byte frame
	a_touch_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EV_TOUCH)) |-> (frame_length == 7'd4))
		else $error("touch event with wrong length");

	// Only touch events carry component id and action
	a_touch_args: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind != EV_TOUCH)) |-> ((second_arg == 8'd0) && !pressed))
		else $error("touch fields set on non-touch event");

	// Overflow reports no length and no argument
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EV_OVERFLOW)) |->
			((frame_length == 7'd0) && (first_arg == 8'd0)))
		else $error("overflow event with payload");

endmodule

bind display_reply_frame_parser drp_checker u_drp_checker (.*);
